// File: hw/rtl/soqt_pkg.sv
// Shared types and codes for the sphere overlap query table.
package soqt_pkg;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_QUERY  = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_FIND   = 3'd4
    } t_kind;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    localparam int RESULT_CAP = 64;

    typedef struct packed {
        logic [15:0]        handle;
        logic [15:0]        radius;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_entry;

    typedef struct packed {
        logic        last;
        logic        found;
        logic [5:0]  hit_index;
        logic [15:0] hit_handle;
        logic        hit_valid;
        logic [1:0]  status;
    } t_res;

endpackage

// File: hw/rtl/soqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module soqt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/soqt_dist.sv
// Shared squaring unit: sums the squared axis distances and compares with (r1+r2)^2.
module soqt_dist import soqt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_entry i_query,
    input  t_entry i_entry,
    output logic   o_done,
    output logic   o_hit
);
    logic        r_busy;
    logic [1:0]  r_step;
    logic        r_pv;
    logic [1:0]  r_pstep;
    logic [33:0] r_prod;
    logic [35:0] r_acc;
    logic        r_done;
    logic        r_hit;

    logic signed [16:0] diff;
    logic [16:0]        op;

    always_comb begin
        diff = '0;
        op   = '0;
        case (r_step)
            2'd0: diff = $signed({i_query.x[15], i_query.x}) - $signed({i_entry.x[15], i_entry.x});
            2'd1: diff = $signed({i_query.y[15], i_query.y}) - $signed({i_entry.y[15], i_entry.y});
            2'd2: diff = $signed({i_query.z[15], i_query.z}) - $signed({i_entry.z[15], i_entry.z});
            default: diff = '0;
        endcase
        if (r_step == 2'd3) begin
            op = {1'b0, i_query.radius} + {1'b0, i_entry.radius};
        end else begin
            op = diff[16] ? 17'(-diff) : 17'(diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_pv && (r_pstep == 2'd3);
            r_pv   <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The product register separates the multiplier from the accumulator.
    always_ff @(posedge i_clk) begin
        r_pstep <= r_step;
        r_prod  <= op * op;
        if (r_pv) begin
            case (r_pstep)
                2'd0:    r_acc <= {2'b00, r_prod};
                2'd3:    r_hit <= r_acc < {2'b00, r_prod};
                default: r_acc <= r_acc + {2'b00, r_prod};
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hit  = r_hit;
endmodule

// File: hw/rtl/sphere_overlap_query_table.sv
// Top level: sphere table with sequencer, entry memory and shared distance unit.
//
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tuser: kind; tdata: item fields
// m_axis    out        m_axis_tvalid/tready      tdata: result fields; tlast: last
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Add, clear and unused kinds go straight to the result; remove shifts each later entry
// down one slot with a read and a write. Find reads and checks one entry at a time; a query
// skips entries with its own handle and tests each other one with four passes through the
// single squaring multiplier, its product register and its accumulator.
// Reset empties the table; memory contents are not cleared.
// A full output register stalls the sequencer until m_axis_tready frees it.
module sphere_overlap_query_table import soqt_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // handle[15:0], pos_x[31:16], pos_y[47:32], pos_z[63:48], radius[79:64],
    // index[85:80], zero pad[87:86]
    input  logic [87:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], hit_valid[2], hit_handle[18:3], hit_index[24:19], found[25],
    // zero pad[31:26]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WW = (CW > 6) ? CW : 6;
    localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SH = 16 - CB;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SH_RD = 8'b00000010,
        S_SH_WR = 8'b00000100,
        S_RD    = 8'b00001000,
        S_CHK   = 8'b00010000,
        S_CALC  = 8'b00100000,
        S_HIT   = 8'b01000000,
        S_EMIT  = 8'b10000000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_ptr;
    logic [6:0]      r_nhits;
    logic            r_held_v;
    t_res            r_held;
    t_res            r_res;
    t_res            r_out;
    logic            r_ovalid;
    t_kind           r_kind;
    t_entry          r_q;

    t_entry          in_entry;
    t_kind           in_kind;
    logic [5:0]      in_index;
    logic signed [15:0] sx, sy, sz;
    t_entry          rdata;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic            accept;
    logic            slot_free;
    logic            out_load;
    t_res            out_next;
    logic            dist_start;
    logic            dist_done;
    logic            dist_hit;
    logic            at_end;
    t_res            end_res;
    t_res            cur_res;
    t_res            last_res;
    t_res            ok_res;
    t_res            idle_res;
    logic [WW-1:0]   idx_w;
    logic [WW-1:0]   cnt_w;
    logic [WW-1:0]   ptr_w;
    logic            handle_eq;

    always_comb begin
        sx = s_axis_tdata[31:16] << SH;
        sy = s_axis_tdata[47:32] << SH;
        sz = s_axis_tdata[63:48] << SH;
        in_entry.handle = s_axis_tdata[15:0];
        in_entry.radius = s_axis_tdata[79:64];
        in_entry.x      = sx >>> SH;
        in_entry.y      = sy >>> SH;
        in_entry.z      = sz >>> SH;
    end

    assign in_kind   = t_kind'(s_axis_tuser);
    assign in_index  = s_axis_tdata[85:80];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_ovalid || m_axis_tready;
    assign idx_w     = WW'(in_index);
    assign cnt_w     = WW'(r_count);
    assign ptr_w     = WW'(r_ptr);
    assign at_end    = (r_ptr == '0);
    assign handle_eq = (rdata.handle == r_q.handle);

    always_comb begin
        ok_res        = '0;
        ok_res.last   = 1'b1;
        cur_res            = '0;
        cur_res.hit_valid  = 1'b1;
        cur_res.hit_handle = rdata.handle;
        cur_res.hit_index  = ptr_w[5:0];
        last_res      = cur_res;
        last_res.last = 1'b1;
        end_res      = r_held_v ? r_held : ok_res;
        end_res.last = 1'b1;
        idle_res     = ok_res;
        if (in_kind == KIND_ADD && r_count >= CW'(MAX_ENTRIES)) begin
            idle_res.status = STATUS_FULL;
        end
        if (in_kind == KIND_REMOVE && idx_w >= cnt_w) begin
            idle_res.status = STATUS_BAD;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = rdata;
        ram_raddr = r_ptr;
        if (r_state == S_IDLE) begin
            ram_we    = accept && in_kind == KIND_ADD && r_count < CW'(MAX_ENTRIES);
            ram_waddr = r_count[AW-1:0];
            ram_wdata = in_entry;
        end else if (r_state == S_SH_WR) begin
            ram_we = 1'b1;
        end
        if (r_state == S_SH_RD) begin
            ram_raddr = r_ptr + AW'(1);
        end
    end

    assign dist_start = (r_state == S_CHK) && !handle_eq && r_kind == KIND_QUERY;

    always_comb begin
        out_load = 1'b0;
        out_next = r_res;
        if (r_state == S_EMIT && slot_free) begin
            out_load = 1'b1;
        end else if (r_state == S_HIT && slot_free && r_held_v) begin
            out_load = 1'b1;
            out_next = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_held_v <= 1'b0;
            r_nhits  <= '0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_out    <= out_next;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_q      <= in_entry;
                        r_kind   <= in_kind;
                        r_held_v <= 1'b0;
                        r_nhits  <= '0;
                        r_res    <= idle_res;
                        case (in_kind) inside
                            KIND_ADD: begin
                                r_state <= S_EMIT;
                                if (r_count < CW'(MAX_ENTRIES)) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            KIND_REMOVE: begin
                                if (idx_w >= cnt_w) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_ptr <= idx_w[AW-1:0];
                                    if (idx_w + WW'(1) < cnt_w) begin
                                        r_state <= S_SH_RD;
                                    end else begin
                                        r_count <= r_count - CW'(1);
                                        r_state <= S_EMIT;
                                    end
                                end
                            end
                            KIND_QUERY, KIND_FIND: begin
                                if (r_count != '0) begin
                                    r_ptr   <= AW'(r_count - CW'(1));
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            KIND_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_EMIT;
                            end
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    if (CW'(r_ptr) + CW'(2) < r_count) begin
                        r_ptr   <= r_ptr + AW'(1);
                        r_state <= S_SH_RD;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_EMIT;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (handle_eq && r_kind == KIND_FIND) begin
                        r_res.found <= 1'b1;
                        r_state     <= S_EMIT;
                    end else if (dist_start) begin
                        r_state <= S_CALC;
                    end else if (at_end) begin
                        r_res   <= end_res;
                        r_state <= S_EMIT;
                    end else begin
                        r_ptr   <= r_ptr - AW'(1);
                        r_state <= S_RD;
                    end
                end
                S_CALC: begin
                    if (dist_done) begin
                        if (dist_hit) begin
                            r_state <= S_HIT;
                        end else if (at_end) begin
                            r_res   <= end_res;
                            r_state <= S_EMIT;
                        end else begin
                            r_ptr   <= r_ptr - AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_HIT: begin
                    // A held hit goes out first, so the newest hit can still take last.
                    if (slot_free || !r_held_v) begin
                        r_nhits <= r_nhits + 7'd1;
                        if (r_nhits + 7'd1 == 7'(RESULT_CAP) || at_end) begin
                            r_res   <= last_res;
                            r_state <= S_EMIT;
                        end else begin
                            r_held   <= cur_res;
                            r_held_v <= 1'b1;
                            r_ptr    <= r_ptr - AW'(1);
                            r_state  <= S_RD;
                        end
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    soqt_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    soqt_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_query (r_q),
        .i_entry (rdata),
        .o_done  (dist_done),
        .o_hit   (dist_hit)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_out.found, r_out.hit_index, r_out.hit_handle,
                            r_out.hit_valid, r_out.status};
    assign m_axis_tlast  = r_out.last;
endmodule

// File: tb/tb_overlap_checker.sv
// Checker for the sphere overlap table: predicts results per transaction and compares them.
`timescale 1ns / 1ps
module tb_overlap_checker import soqt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [87:0] i_in_data,
    input  logic [2:0]  i_in_kind,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic        hit_valid;
        logic [15:0] hit_handle;
        logic [5:0]  hit_index;
        logic        found;
        logic        last;
    } t_expect;

    t_entry  sphere_tab[64];
    int      sphere_count;
    t_expect result_fifo[$];
    int      fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = result_fifo.size();

    function automatic t_expect mk(logic [1:0] st, logic hv, logic [15:0] hh,
                                   logic [5:0] hi, logic fd, logic lst);
        t_expect e;
        e.status = st; e.hit_valid = hv; e.hit_handle = hh;
        e.hit_index = hi; e.found = fd; e.last = lst;
        return e;
    endfunction

    function automatic void expect_add(t_expect e);
        result_fifo.insert(result_fifo.size(), e);
    endfunction

    function automatic logic [63:0] sq_diff(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [63:0] d;
        d = 64'(a) - 64'(b);
        return d * d;
    endfunction

    task automatic predict_item(logic [2:0] kind, logic [87:0] d);
        t_entry      q;
        logic [5:0]  idx;
        logic [63:0] dist2, rsum;
        int          hits;
        logic        hit;
        q.handle = d[15:0];  q.x = d[31:16]; q.y = d[47:32];
        q.z = d[63:48];      q.radius = d[79:64];
        idx = d[85:80];
        hits = 0;
        hit = 1'b0;
        case (kind)
            KIND_ADD: begin
                if (sphere_count >= 64) begin
                    expect_add(mk(STATUS_FULL, 1'b0, 16'h0, 6'd0, 1'b0, 1'b1));
                end else begin
                    sphere_tab[sphere_count] = q;
                    sphere_count++;
                    expect_add(mk(STATUS_OK, 1'b0, 16'h0, 6'd0, 1'b0, 1'b1));
                end
            end
            KIND_REMOVE: begin
                if (idx >= sphere_count) begin
                    expect_add(mk(STATUS_BAD, 1'b0, 16'h0, 6'd0, 1'b0, 1'b1));
                end else begin
                    for (int i = idx; i + 1 < sphere_count; i++)
                        sphere_tab[i] = sphere_tab[i + 1];
                    sphere_count--;
                    expect_add(mk(STATUS_OK, 1'b0, 16'h0, 6'd0, 1'b0, 1'b1));
                end
            end
            KIND_QUERY: begin
                for (int i = sphere_count - 1; i >= 0 && hits < RESULT_CAP; i--) begin
                    if (sphere_tab[i].handle != q.handle) begin
                        dist2 = sq_diff(q.x, sphere_tab[i].x) + sq_diff(q.y, sphere_tab[i].y)
                              + sq_diff(q.z, sphere_tab[i].z);
                        rsum = 64'(q.radius) + 64'(sphere_tab[i].radius);
                        if (dist2 < rsum * rsum) begin
                            expect_add(mk(STATUS_OK, 1'b1, sphere_tab[i].handle,
                                          6'(i), 1'b0, 1'b0));
                            hits++;
                        end
                    end
                end
                if (hits == 0)
                    expect_add(mk(STATUS_OK, 1'b0, 16'h0, 6'd0, 1'b0, 1'b1));
                else
                    result_fifo[$].last = 1'b1;
            end
            KIND_CLEAR: begin
                sphere_count = 0;
                expect_add(mk(STATUS_OK, 1'b0, 16'h0, 6'd0, 1'b0, 1'b1));
            end
            KIND_FIND: begin
                for (int i = 0; i < sphere_count; i++)
                    if (sphere_tab[i].handle == q.handle) hit = 1'b1;
                expect_add(mk(STATUS_OK, 1'b0, 16'h0, 6'd0, hit, 1'b1));
            end
            default: expect_add(mk(STATUS_OK, 1'b0, 16'h0, 6'd0, 1'b0, 1'b1));
        endcase
    endtask

    always @(posedge i_clk) begin
        t_expect got, want;
        if (!i_rst_n) begin
            sphere_count = 0;
            result_fifo.delete();
            fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = mk(i_out_data[1:0], i_out_data[2], i_out_data[18:3],
                         i_out_data[24:19], i_out_data[25], i_out_last);
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = result_fifo.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch, expected st=%0d hv=%0d hh=%h hi=%0d fd=%0d last=%0d, actual st=%0d hv=%0d hh=%h hi=%0d fd=%0d last=%0d",
                                 $time, want.status, want.hit_valid, want.hit_handle,
                                 want.hit_index, want.found, want.last, got.status,
                                 got.hit_valid, got.hit_handle, got.hit_index, got.found,
                                 got.last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_in_kind, i_in_data);
        end
    end

endmodule

// File: tb/tb_top.sv
// Testbench top: stimulus, stalls and verdict for the sphere overlap table.
`timescale 1ns / 1ps
module tb_top;
    import soqt_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count, pending;
    int          idle_cycles = 0;
    int          hold_req = 0;
    bit          calm;
    logic [15:0] used_handles[$];

    always #5 i_clk = ~i_clk;

    sphere_overlap_query_table u_top (.*);

    tb_overlap_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_kind(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: a query with many stalled hits is the slowest case.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sink: random stall bursts, a long hold-off on request, none when calm.
    initial begin
        int n;
        int hold_seen;
        hold_seen = 0;
        @(posedge i_clk);
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send(logic [2:0] kind, logic [15:0] h, logic [15:0] x, logic [15:0] y,
                        logic [15:0] z, logic [15:0] r, logic [5:0] idx);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, idx, r, z, y, x, h};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Clustered spheres so that queries find plenty of overlaps.
    task automatic send_rand(logic [2:0] kind);
        logic [15:0] h;
        bit          wide;
        h = (used_handles.size() > 0 && $urandom_range(0, 2) == 0)
            ? used_handles[$urandom_range(0, used_handles.size() - 1)] : 16'($urandom);
        if (kind == KIND_ADD) used_handles.insert(used_handles.size(), h);
        wide = ($urandom_range(0, 5) == 0);
        send(kind, h,
             wide ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024),
             wide ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024),
             wide ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024),
             wide ? 16'($urandom) : 16'($urandom_range(0, 1023)),
             6'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int k;
        calm = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-table cases, field extremes, unused kinds.
        send(KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0);
        send(KIND_REMOVE, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        send(KIND_FIND, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 6'd63);
        send(KIND_ADD, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 6'd63);
        send(KIND_ADD, 16'h0001, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 6'd0);
        send(KIND_ADD, 16'h0002, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 6'd0);
        send(KIND_QUERY, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 6'd0);
        send(KIND_QUERY, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 6'd0);
        send(KIND_QUERY, 16'h0009, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 6'd0);
        // Small query sphere offset from handle 1 in x: well inside the radius sum, so an overlap.
        send(KIND_QUERY, 16'h0009, 16'h8100, 16'h8000, 16'h8000, 16'h0001, 6'd0);
        send(KIND_FIND, 16'h0002, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        send(KIND_REMOVE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd3);
        send(KIND_REMOVE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        send(KIND_FIND, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        send(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
        send(3'd6, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        send(3'd7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        send(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        drain();

        // Fill the table with overlapping spheres, then hit the full status and 64-hit cap.
        for (k = 0; k < 64; k++)
            send(KIND_ADD, 16'(k + 100), 16'(k), 16'h0, 16'h0, 16'h0100, 6'd0);
        send(KIND_ADD, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        hold_req++;
        send(KIND_QUERY, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0100, 6'd0);
        send(KIND_QUERY, 16'd100, 16'h0, 16'h0, 16'h0, 16'h0100, 6'd0);
        send(KIND_REMOVE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd63);
        send(KIND_REMOVE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);
        send(KIND_QUERY, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0100, 6'd0);
        drain();
        send(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0);

        // Random part: mostly adds and queries, sometimes clearing to reuse the table.
        for (k = 0; k < 240; k++) begin
            if (k == 200) begin
                drain();
                calm = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: send_rand(KIND_ADD);
                8, 9, 10, 11, 12, 13:   send_rand(KIND_QUERY);
                14, 15:                 send_rand(KIND_REMOVE);
                16, 17:                 send_rand(KIND_FIND);
                18:                     send_rand(($urandom_range(0, 3) == 0) ? KIND_CLEAR
                                                                          : 3'($urandom_range(5, 7)));
                default:                send_rand(KIND_QUERY);
            endcase
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/soqt_pkg.sv
hw/rtl/soqt_ram.sv
hw/rtl/soqt_dist.sv
hw/rtl/sphere_overlap_query_table.sv
tb/tb_overlap_checker.sv
tb/tb_top.sv
